FILE: rtl/grid_bucket_shortest_path_field_defines.svh
// ----------------------------------------------------------------------------
// grid bucket shortest path field assertion macros
// shared property forms for the assertions of the block
// ----------------------------------------------------------------------------
`ifndef GRID_BUCKET_SHORTEST_PATH_FIELD_DEFINES_SVH
`define GRID_BUCKET_SHORTEST_PATH_FIELD_DEFINES_SVH

// same-cycle implication
`define GBSP_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GBSP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/gbsp_pkg.sv
// ----------------------------------------------------------------------------
// gbsp_pkg
// types and codes of the grid shortest path field
// ----------------------------------------------------------------------------
package gbsp_pkg;

  localparam int DIST_W = 17;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [DIST_W:0]   score_t;
  localparam dist_t DIST_UNREACH = 17'h1FFFF;

  typedef enum logic [1:0] {
    FN_LOAD    = 2'd0,
    FN_COMPUTE = 2'd1,
    FN_QUERY   = 2'd2,
    FN_NONE    = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    DIR_NONE   = 3'd0,
    DIR_NEG_X  = 3'd1,
    DIR_NEG_Z  = 3'd2,
    DIR_POS_X  = 3'd3,
    DIR_POS_Z  = 3'd4,
    DIR_TARGET = 3'd5
  } dir_e;

  localparam logic [1:0] CFG_TARGET_X = 2'd0;
  localparam logic [1:0] CFG_TARGET_Z = 2'd1;

  // scan slots, numbered like the direction codes
  localparam logic [2:0] SLOT_CENTER = 3'd0;
  localparam logic [2:0] SLOT_NEG_X  = 3'd1;
  localparam logic [2:0] SLOT_NEG_Z  = 3'd2;
  localparam logic [2:0] SLOT_POS_X  = 3'd3;
  localparam logic [2:0] SLOT_POS_Z  = 3'd4;
  localparam logic [2:0] PHASE_LAST  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_TREAD,
    ST_TCHK,
    ST_SCAN,
    ST_WRITE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic       start;
    logic       capture;
    logic [2:0] slot;
    logic       ok;
  } pick_ctl_t;

endpackage

FILE: rtl/gbsp_store.sv
// ----------------------------------------------------------------------------
// gbsp_store
// cell cost memory and distance memory, one shared read address
// ----------------------------------------------------------------------------
module gbsp_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int KW    = 5
) (
  input  logic                  clk_i,
  input  logic                  cost_we_i,
  input  logic [AW-1:0]         cost_waddr_i,
  input  logic [KW:0]           cost_wdata_i,
  input  logic                  dist_we_i,
  input  logic [AW-1:0]         dist_waddr_i,
  input  gbsp_pkg::dist_t       dist_wdata_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [KW:0]           cost_rdata_o,
  output gbsp_pkg::dist_t       dist_rdata_o
);
  import gbsp_pkg::*;

  logic [KW:0] cost_mem [DEPTH];
  dist_t       dist_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (cost_we_i) begin
      cost_mem[cost_waddr_i] <= cost_wdata_i;
    end
    cost_rdata_o <= cost_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (dist_we_i) begin
      dist_mem[dist_waddr_i] <= dist_wdata_i;
    end
    dist_rdata_o <= dist_mem[raddr_i];
  end

endmodule

FILE: rtl/gbsp_pick.sv
// ----------------------------------------------------------------------------
// gbsp_pick
// running minimum of neighbor distance plus neighbor cost over one scan
// ----------------------------------------------------------------------------
module gbsp_pick #(
  parameter int KW = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gbsp_pkg::pick_ctl_t   ctl_i,
  input  logic                  blocked_i,
  input  logic [KW-1:0]         cost_i,
  input  gbsp_pkg::dist_t       dist_i,
  output gbsp_pkg::score_t      best_score_o,
  output gbsp_pkg::dir_e        best_dir_o
);
  import gbsp_pkg::*;

  score_t score;
  logic   qualify;
  score_t best_q;
  dir_e   dir_q;

  assign score   = {1'b0, dist_i} + (DIST_W+1)'(cost_i);
  assign qualify = ctl_i.capture && ctl_i.ok && (ctl_i.slot != SLOT_CENTER) && !blocked_i
                   && (dist_i != DIST_UNREACH) && (score < best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '1;
      dir_q  <= DIR_NONE;
    end else if (ctl_i.start) begin
      best_q <= '1;
      dir_q  <= DIR_NONE;
    end else if (qualify) begin
      best_q <= score;
      dir_q  <= dir_e'(ctl_i.slot);
    end
  end

  assign best_score_o = best_q;
  assign best_dir_o   = dir_q;

endmodule

FILE: rtl/grid_bucket_shortest_path_field.sv
// ----------------------------------------------------------------------------
// grid_bucket_shortest_path_field
// cost distance field over a square grid with step directions to a target
// ----------------------------------------------------------------------------
// channel  dir  handshake               payload
// cfg      in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
// in       in   in_valid_i/in_ready_o   func_i, cell_x_i, cell_z_i, cell_cost_i,
//                                       cell_blocked_i
// out      out  out_valid_o/out_ready_i field_ready_o, distance_o, direction_o
//
// load and unused codes go straight to the finish state; a query scans its cell and
// neighbors with one read per cell visited on the shared memory read port
// compute clears every cell, reads and checks the target, then runs relaxation
// sweeps over every cell, sweeps alternating direction until one changes nothing
// reset clears control state only; the distance memory reads unreachable until
// the first compute
// a waiting result holds the block in its finish state until taken
// ----------------------------------------------------------------------------
`include "grid_bucket_shortest_path_field_defines.svh"

module grid_bucket_shortest_path_field #(
  parameter int GRID_SIDE = 64,
  parameter int MAX_COST  = 25
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [5:0]            cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            func_i,
  input  logic [5:0]            cell_x_i,
  input  logic [5:0]            cell_z_i,
  input  logic [4:0]            cell_cost_i,
  input  logic                  cell_blocked_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  field_ready_o,
  output gbsp_pkg::dist_t       distance_o,
  output logic [2:0]            direction_o
);
  import gbsp_pkg::*;

  localparam int CW    = $clog2(GRID_SIDE);
  localparam int DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(MAX_COST + 1);
  localparam logic [CW-1:0] XMAX = CW'(GRID_SIDE - 1);

  function automatic logic [AW-1:0] cell_addr(input logic [31:0] x, input logic [31:0] z);
    return AW'(z * GRID_SIDE + x);
  endfunction

  state_e        state_q, state_d;
  logic [5:0]    tx_q, tx_d, tz_q, tz_d;
  logic          ready_q, ready_d, seen_q, seen_d;
  logic [CW-1:0] x_q, x_d, z_q, z_d;
  logic [2:0]    phase_q, phase_d, slot_q, slot_d;
  logic          slot_ok_q, slot_ok_d;
  logic          qmode_q, qmode_d, bwd_q, bwd_d, changed_q, changed_d;
  logic          cblk_q, cblk_d;
  dist_t         cdist_q, cdist_d, res_dist_q, res_dist_d;
  dir_e          res_dir_q, res_dir_d;
  logic          out_valid_q, out_valid_d, out_ready_flag_q, out_ready_flag_d;
  dist_t         out_dist_q, out_dist_d;
  dir_e          out_dir_q, out_dir_d;

  logic          cost_we, dist_we;
  logic [AW-1:0] cost_waddr, dist_waddr, raddr;
  logic [KW:0]   cost_wdata, cost_rdata;
  dist_t         dist_wdata, dist_rdata, dist_eff;
  logic [KW-1:0] sat_cost;
  logic [CW-1:0] sx, sz;
  logic          sok, in_range, tgt_in, at_target, last, relax;
  logic [AW-1:0] tgt_addr, ctr_addr;
  pick_ctl_t     pick_ctl;
  score_t        best_score;
  dir_e          best_dir;

  gbsp_store #(.DEPTH(DEPTH), .AW(AW), .KW(KW)) u_store (
    .clk_i        (clk_i),
    .cost_we_i    (cost_we),
    .cost_waddr_i (cost_waddr),
    .cost_wdata_i (cost_wdata),
    .dist_we_i    (dist_we),
    .dist_waddr_i (dist_waddr),
    .dist_wdata_i (dist_wdata),
    .raddr_i      (raddr),
    .cost_rdata_o (cost_rdata),
    .dist_rdata_o (dist_rdata)
  );

  gbsp_pick #(.KW(KW)) u_pick (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (pick_ctl),
    .blocked_i    (cost_rdata[KW]),
    .cost_i       (cost_rdata[KW-1:0]),
    .dist_i       (dist_eff),
    .best_score_o (best_score),
    .best_dir_o   (best_dir)
  );

  assign dist_eff  = seen_q ? dist_rdata : DIST_UNREACH;
  assign tgt_in    = (32'(tx_q) < GRID_SIDE) && (32'(tz_q) < GRID_SIDE);
  assign tgt_addr  = cell_addr(32'(tx_q), 32'(tz_q));
  assign ctr_addr  = cell_addr(32'(x_q), 32'(z_q));
  assign in_range  = (32'(cell_x_i) < GRID_SIDE) && (32'(cell_z_i) < GRID_SIDE);
  assign at_target = (32'(x_q) == 32'(tx_q)) && (32'(z_q) == 32'(tz_q));
  assign last      = bwd_q ? (x_q == '0 && z_q == '0) : (x_q == XMAX && z_q == XMAX);
  assign relax     = !qmode_q && !cblk_q && (best_score < {1'b0, cdist_q});

  always_comb begin
    if (cell_cost_i == '0) begin
      sat_cost = KW'(1);
    end else if (32'(cell_cost_i) > MAX_COST) begin
      sat_cost = KW'(MAX_COST);
    end else begin
      sat_cost = KW'(cell_cost_i);
    end
  end

  // neighbor of the current cell for the slot being issued
  always_comb begin
    sx  = x_q;
    sz  = z_q;
    sok = 1'b1;
    case (phase_q)
      SLOT_NEG_X: begin
        sok = (x_q != '0);
        sx  = x_q - CW'(1);
      end
      SLOT_NEG_Z: begin
        sok = (z_q != '0);
        sz  = z_q - CW'(1);
      end
      SLOT_POS_X: begin
        sok = (x_q != XMAX);
        sx  = x_q + CW'(1);
      end
      SLOT_POS_Z: begin
        sok = (z_q != XMAX);
        sz  = z_q + CW'(1);
      end
      default: begin
      end
    endcase
  end

  assign raddr = (state_q == ST_TREAD) ? tgt_addr : cell_addr(32'(sx), 32'(sz));

  assign pick_ctl.start   = (state_q == ST_SCAN) && (phase_q == SLOT_CENTER);
  assign pick_ctl.capture = (state_q == ST_SCAN) && (phase_q != SLOT_CENTER);
  assign pick_ctl.slot    = slot_q;
  assign pick_ctl.ok      = slot_ok_q;

  always_comb begin
    state_d          = state_q;
    tx_d             = tx_q;
    tz_d             = tz_q;
    ready_d          = ready_q;
    seen_d           = seen_q;
    x_d              = x_q;
    z_d              = z_q;
    phase_d          = phase_q;
    slot_d           = slot_q;
    slot_ok_d        = slot_ok_q;
    qmode_d          = qmode_q;
    bwd_d            = bwd_q;
    changed_d        = changed_q;
    cblk_d           = cblk_q;
    cdist_d          = cdist_q;
    res_dist_d       = res_dist_q;
    res_dir_d        = res_dir_q;
    out_valid_d      = out_valid_q && !out_ready_i;
    out_ready_flag_d = out_ready_flag_q;
    out_dist_d       = out_dist_q;
    out_dir_d        = out_dir_q;
    in_ready_o       = 1'b0;
    cost_we          = 1'b0;
    cost_waddr       = cell_addr(32'(cell_x_i), 32'(cell_z_i));
    cost_wdata       = {cell_blocked_i, sat_cost};
    dist_we          = 1'b0;
    dist_waddr       = ctr_addr;
    dist_wdata       = DIST_UNREACH;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TARGET_X: tx_d = cfg_data_i;
        CFG_TARGET_Z: tz_d = cfg_data_i;
        default: begin
        end
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_dist_d = DIST_UNREACH;
          res_dir_d  = DIR_NONE;
          x_d        = CW'(cell_x_i);
          z_d        = CW'(cell_z_i);
          state_d    = ST_FINISH;
          case (func_e'(func_i))
            FN_LOAD: begin
              cost_we = in_range;
              ready_d = 1'b0;
            end
            FN_COMPUTE: begin
              ready_d = 1'b0;
              seen_d  = 1'b1;
              x_d     = '0;
              z_d     = '0;
              bwd_d   = 1'b0;
              state_d = ST_CLEAR;
            end
            FN_QUERY: begin
              if (in_range) begin
                qmode_d = 1'b1;
                phase_d = SLOT_CENTER;
                state_d = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_CLEAR: begin
        dist_we = 1'b1;
        if (x_q == XMAX && z_q == XMAX) begin
          state_d = ST_TREAD;
        end else if (x_q == XMAX) begin
          x_d = '0;
          z_d = z_q + CW'(1);
        end else begin
          x_d = x_q + CW'(1);
        end
      end
      ST_TREAD: begin
        state_d = ST_TCHK;
      end
      ST_TCHK: begin
        if (tgt_in && !cost_rdata[KW]) begin
          dist_we    = 1'b1;
          dist_waddr = tgt_addr;
          dist_wdata = '0;
          x_d        = '0;
          z_d        = '0;
          bwd_d      = 1'b0;
          changed_d  = 1'b0;
          qmode_d    = 1'b0;
          phase_d    = SLOT_CENTER;
          state_d    = ST_SCAN;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_SCAN: begin
        slot_d    = phase_q;
        slot_ok_d = sok;
        phase_d   = phase_q + 3'd1;
        if (phase_q != SLOT_CENTER && slot_q == SLOT_CENTER) begin
          cblk_d  = cost_rdata[KW];
          cdist_d = dist_eff;
        end
        if (phase_q == PHASE_LAST) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        phase_d = SLOT_CENTER;
        if (qmode_q) begin
          res_dist_d = cdist_q;
          if (!ready_q || cblk_q || cdist_q == DIST_UNREACH) begin
            res_dir_d = DIR_NONE;
          end else if (at_target) begin
            res_dir_d = DIR_TARGET;
          end else begin
            res_dir_d = best_dir;
          end
          state_d = ST_FINISH;
        end else begin
          if (relax) begin
            dist_we    = 1'b1;
            dist_wdata = best_score[DIST_W-1:0];
          end
          changed_d = changed_q || relax;
          state_d   = ST_SCAN;
          if (last) begin
            if (changed_q || relax) begin
              bwd_d     = !bwd_q;
              changed_d = 1'b0;
            end else begin
              ready_d = 1'b1;
              state_d = ST_FINISH;
            end
          end else if (bwd_q) begin
            if (x_q == '0) begin
              x_d = XMAX;
              z_d = z_q - CW'(1);
            end else begin
              x_d = x_q - CW'(1);
            end
          end else begin
            if (x_q == XMAX) begin
              x_d = '0;
              z_d = z_q + CW'(1);
            end else begin
              x_d = x_q + CW'(1);
            end
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d      = 1'b1;
          out_ready_flag_d = ready_q;
          out_dist_d       = res_dist_q;
          out_dir_d        = res_dir_q;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tx_q        <= '0;
      tz_q        <= '0;
      ready_q     <= 1'b0;
      seen_q      <= 1'b0;
      phase_q     <= SLOT_CENTER;
      slot_q      <= SLOT_CENTER;
      slot_ok_q   <= 1'b0;
      qmode_q     <= 1'b0;
      bwd_q       <= 1'b0;
      changed_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tx_q        <= tx_d;
      tz_q        <= tz_d;
      ready_q     <= ready_d;
      seen_q      <= seen_d;
      phase_q     <= phase_d;
      slot_q      <= slot_d;
      slot_ok_q   <= slot_ok_d;
      qmode_q     <= qmode_d;
      bwd_q       <= bwd_d;
      changed_q   <= changed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q              <= x_d;
    z_q              <= z_d;
    cblk_q           <= cblk_d;
    cdist_q          <= cdist_d;
    res_dist_q       <= res_dist_d;
    res_dir_q        <= res_dir_d;
    out_ready_flag_q <= out_ready_flag_d;
    out_dist_q       <= out_dist_d;
    out_dir_q        <= out_dir_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign field_ready_o = out_ready_flag_q;
  assign distance_o    = out_dist_q;
  assign direction_o   = out_dir_q;

  `GBSP_ASSERT_NEXT(a_accept_leaves_idle, in_valid_i && in_ready_o, state_q != ST_IDLE,
    "accepted item did not leave idle")
  `GBSP_ASSERT_IMPL(a_ready_from_sweep, $rose(ready_q), $past(state_q) == ST_WRITE,
    "field ready set outside a sweep end")
  `GBSP_ASSERT_IMPL(a_result_from_finish, $rose(out_valid_q), $past(state_q) == ST_FINISH,
    "result shown without finishing an item")
  `GBSP_ASSERT_IMPL(a_relax_lowers, dist_we && state_q == ST_WRITE,
    best_score < {1'b0, cdist_q}, "relaxation did not lower a distance")

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// grid shortest path field testbench
// loads the whole grid, runs compute commands over several targets and checks
// every load, compute and query result against a behavioral distance field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import gbsp_pkg::*;

  localparam int SIDE = 64;
  localparam int CELLS = SIDE * SIDE;
  localparam int COST_CAP = 25;
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;
  localparam longint CYCLE_LIMIT = 60_000_000;

  typedef struct {
    func_e      func;
    logic [5:0] x;
    logic [5:0] z;
    logic [4:0] cost;
    logic       blk;
  } cell_op_t;

  typedef struct {
    logic       ready;
    dist_t      path_dist;
    logic [2:0] dir;
  } field_ans_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [5:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = '0;
  logic [5:0] cell_x = '0;
  logic [5:0] cell_z = '0;
  logic [4:0] cell_cost = '0;
  logic cell_blocked = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic field_ready;
  dist_t distance;
  logic [2:0] direction;

  cell_op_t pending_ops[$];
  field_ans_t expected_ans[$];
  cell_op_t driven_op;
  int fail_count = 0;
  longint cycles = 0;
  bit hold_req = 0;

  // shadow field state
  logic [4:0] cost_mem [CELLS];
  logic       blk_mem [CELLS];
  dist_t      dist_mem [CELLS];
  logic       fld_ready = 1'b0;
  logic [5:0] goal_x = '0;
  logic [5:0] goal_z = '0;

  always #6 clk = ~clk;

  grid_bucket_shortest_path_field dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .func_i(func), .cell_x_i(cell_x), .cell_z_i(cell_z),
    .cell_cost_i(cell_cost), .cell_blocked_i(cell_blocked),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .field_ready_o(field_ready), .distance_o(distance), .direction_o(direction)
  );

  function automatic void queue_op(cell_op_t op);
    pending_ops.insert(pending_ops.size(), op);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int cell_idx(int x, int z);
    return z * SIDE + x;
  endfunction

  function automatic void flood_field();
    bit changed;
    int x, z, k, nx, nz, i, n;
    int dx [4] = '{-1, 0, 1, 0};
    int dz [4] = '{0, -1, 0, 1};
    int cand;
    for (i = 0; i < CELLS; i++) dist_mem[i] = DIST_UNREACH;
    fld_ready = 1'b0;
    if (blk_mem[cell_idx(goal_x, goal_z)]) return;
    dist_mem[cell_idx(goal_x, goal_z)] = '0;
    do begin
      changed = 0;
      for (z = 0; z < SIDE; z++) begin
        for (x = 0; x < SIDE; x++) begin
          i = cell_idx(x, z);
          if (dist_mem[i] == DIST_UNREACH) continue;
          for (k = 0; k < 4; k++) begin
            nx = x + dx[k];
            nz = z + dz[k];
            if (nx < 0 || nz < 0 || nx >= SIDE || nz >= SIDE) continue;
            n = cell_idx(nx, nz);
            if (blk_mem[n]) continue;
            cand = int'(dist_mem[i]) + int'(cost_mem[i]);
            if (cand >= int'(DIST_UNREACH) || cand >= int'(dist_mem[n])) continue;
            dist_mem[n] = dist_t'(cand);
            changed = 1;
          end
        end
      end
    end while (changed);
    fld_ready = 1'b1;
  endfunction

  function automatic logic [2:0] step_toward(int x, int z);
    int dx [4] = '{-1, 0, 1, 0};
    int dz [4] = '{0, -1, 0, 1};
    dir_e dirs [4] = '{DIR_NEG_X, DIR_NEG_Z, DIR_POS_X, DIR_POS_Z};
    logic [2:0] best;
    longint best_score, score;
    int k, nx, nz, n, i;
    best = DIR_NONE;
    best_score = 64'h7FFF_FFFF;
    i = cell_idx(x, z);
    if (!fld_ready) return DIR_NONE;
    if (blk_mem[i] || dist_mem[i] == DIST_UNREACH) return DIR_NONE;
    if (x == goal_x && z == goal_z) return DIR_TARGET;
    for (k = 0; k < 4; k++) begin
      nx = x + dx[k];
      nz = z + dz[k];
      if (nx < 0 || nz < 0 || nx >= SIDE || nz >= SIDE) continue;
      n = cell_idx(nx, nz);
      if (blk_mem[n] || dist_mem[n] == DIST_UNREACH) continue;
      score = longint'(dist_mem[n]) + longint'(cost_mem[n]);
      if (score < best_score) begin
        best_score = score;
        best = dirs[k];
      end
    end
    return best;
  endfunction

  function automatic void predict_field(cell_op_t op);
    field_ans_t a;
    int i;
    a.path_dist = DIST_UNREACH;
    a.dir = DIR_NONE;
    i = cell_idx(op.x, op.z);
    case (op.func)
      FN_LOAD: begin
        cost_mem[i] = (op.cost == 0) ? 5'd1 : (op.cost > COST_CAP) ? 5'(COST_CAP) : op.cost;
        blk_mem[i] = op.blk;
        fld_ready = 1'b0;
      end
      FN_COMPUTE: flood_field();
      FN_QUERY: begin
        a.path_dist = dist_mem[i];
        a.dir = step_toward(op.x, op.z);
      end
      default: ;
    endcase
    a.ready = fld_ready;
    expected_ans.insert(expected_ans.size(), a);
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk or negedge rst_n) begin
    logic next_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        predict_field(driven_op);
        next_valid = 1'b0;
        in_gap = pick_gap();
      end
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_ops.size() > 0) begin
          driven_op = pending_ops[0];
          pending_ops.delete(0);
          func <= driven_op.func;
          cell_x <= driven_op.x;
          cell_z <= driven_op.z;
          cell_cost <= driven_op.cost;
          cell_blocked <= driven_op.blk;
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;
    end
  end

  // monitor
  int out_gap = 0;
  int hold_cnt = 0;
  bit hold_done = 0;
  always @(posedge clk or negedge rst_n) begin
    field_ans_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_ans.size() == 0) begin
          $display("%0t: unexpected item ready=%0d dist=%0d dir=%0d", $time,
                   field_ready, distance, direction);
          fail_count++;
        end else begin
          e = expected_ans[0];
          expected_ans.delete(0);
          if (field_ready !== e.ready) begin
            $display("%0t: field_ready expected %0d actual %0d", $time, e.ready, field_ready);
            fail_count++;
          end
          if (distance !== e.path_dist) begin
            $display("%0t: distance expected %0d actual %0d", $time, e.path_dist, distance);
            fail_count++;
          end
          if (direction !== e.dir) begin
            $display("%0t: direction expected %0d actual %0d", $time, e.dir, direction);
            fail_count++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(3) == 0) out_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic cell_op_t mk_op(func_e f, int x, int z, int c, bit b);
    cell_op_t op;
    op.func = f;
    op.x = 6'(x);
    op.z = 6'(z);
    op.cost = 5'(c);
    op.blk = b;
    return op;
  endfunction

  function automatic cell_op_t rand_op();
    int r;
    func_e f;
    r = $urandom_range(99);
    f = (r < 85) ? FN_QUERY : (r < 95) ? FN_LOAD : FN_NONE;
    return mk_op(f, $urandom_range(63), $urandom_range(63), $urandom_range(31),
                 (f == FN_LOAD) ? ($urandom_range(9) == 0) : $urandom_range(1));
  endfunction

  task automatic wait_idle();
    while (pending_ops.size() > 0 || in_valid || expected_ans.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_TARGET_X) goal_x = val;
    else if (idx == CFG_TARGET_Z) goal_z = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic retarget(int x, int z);
    wait_idle();
    write_reg(CFG_TARGET_X, 6'(x));
    write_reg(CFG_TARGET_Z, 6'(z));
  endtask

  task automatic random_run(int n, int computes);
    for (int i = 0; i < n; i++) begin
      if (computes > 0 && i % (n / (computes + 1)) == n / (computes + 1) - 1) begin
        queue_op(mk_op(FN_COMPUTE, 0, 0, 0, 0));
        computes--;
      end else begin
        queue_op(rand_op());
      end
    end
  endtask

  initial begin
    int bx, bz;
    for (int i = 0; i < CELLS; i++) dist_mem[i] = DIST_UNREACH;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    write_reg(CFG_SPARE_A, 6'h3F);
    write_reg(CFG_SPARE_B, 6'h2A);
    write_reg(CFG_TARGET_X, 6'd0);
    write_reg(CFG_TARGET_Z, 6'd0);
    for (int z = 0; z < SIDE; z++) begin
      for (int x = 0; x < SIDE; x++) begin
        int c;
        bit b;
        c = $urandom_range(31);
        b = ($urandom_range(99) < 8);
        if ((x == 0 && z == 0) || (x == 63 && z == 63) || (x == 7 && z == 7)) b = 0;
        if (x == 5 && z == 5) b = 1;
        if (x == 1 && z == 0) c = 0;
        if (x == 0 && z == 1) c = 31;
        queue_op(mk_op(FN_LOAD, x, z, c, b));
      end
    end
    // directed
    queue_op(mk_op(FN_QUERY, 0, 0, 0, 0));
    queue_op(mk_op(FN_NONE, 63, 63, 31, 1));
    queue_op(mk_op(FN_COMPUTE, 0, 0, 0, 0));
    queue_op(mk_op(FN_QUERY, 0, 0, 31, 1));
    queue_op(mk_op(FN_QUERY, 63, 63, 0, 0));
    queue_op(mk_op(FN_QUERY, 0, 63, 0, 0));
    queue_op(mk_op(FN_QUERY, 63, 0, 0, 0));
    queue_op(mk_op(FN_QUERY, 1, 0, 0, 0));
    queue_op(mk_op(FN_QUERY, 5, 5, 0, 0));
    queue_op(mk_op(FN_NONE, 0, 0, 0, 0));
    queue_op(mk_op(FN_LOAD, 7, 7, 0, 0));
    queue_op(mk_op(FN_QUERY, 7, 7, 0, 0));
    queue_op(mk_op(FN_LOAD, 7, 7, 31, 0));
    queue_op(mk_op(FN_COMPUTE, 0, 0, 0, 0));
    queue_op(mk_op(FN_QUERY, 7, 7, 0, 0));
    queue_op(mk_op(FN_QUERY, 8, 7, 0, 0));
    queue_op(mk_op(FN_QUERY, 7, 8, 0, 0));
    queue_op(mk_op(FN_NONE, 0, 0, 0, 0));

    retarget(63, 63);
    queue_op(mk_op(FN_COMPUTE, 0, 0, 0, 0));
    queue_op(mk_op(FN_QUERY, 63, 63, 0, 0));
    random_run(500, 0);

    // blocked goal leaves the field not ready
    bx = $urandom_range(10, 60);
    bz = $urandom_range(10, 60);
    wait_idle();
    queue_op(mk_op(FN_LOAD, bx, bz, 3, 1));
    retarget(bx, bz);
    queue_op(mk_op(FN_COMPUTE, 0, 0, 0, 0));
    queue_op(mk_op(FN_QUERY, bx, bz, 0, 0));
    random_run(200, 0);

    bx = $urandom_range(63);
    bz = $urandom_range(63);
    wait_idle();
    queue_op(mk_op(FN_LOAD, bx, bz, $urandom_range(31), 0));
    retarget(bx, bz);
    queue_op(mk_op(FN_COMPUTE, 0, 0, 0, 0));
    random_run(600, 1);
    wait_idle();
    hold_req = 1;
    random_run(700, 1);
    wait_idle();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && expected_ans.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

FILE: grid_bucket_shortest_path_field.f
+incdir+rtl
rtl/gbsp_pkg.sv
rtl/gbsp_store.sv
rtl/gbsp_pick.sv
rtl/grid_bucket_shortest_path_field.sv
tb/sv/testbench.sv
